// ----- rtl/hfpr_pkg.sv -----
// Shared types and constants for the header-framed packet receiver.
// Holds the frame result type, the sync register pair type and register indexes.
// No dependencies; every other file in this block uses it by scoped names.
`default_nettype none

package hfpr_pkg;

  // Field widths of the byte stream and of one decoded frame.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAYLOAD_W = 48;
  localparam int unsigned PAYLOAD_SLOTS = PAYLOAD_W / BYTE_W;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // Reset values of the header registers.
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // The pair of header bytes the parser compares against.
  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } sync_cfg_t;

  // One decoded frame, handed from the parser to the output register.
  typedef struct packed {
    logic [BYTE_W-1:0]    command;
    logic [PAYLOAD_W-1:0] payload;
    logic                 good;
    logic [BYTE_W-1:0]    sum;
  } frame_t;

endpackage

`default_nettype wire

// ----- rtl/hfpr_if.sv -----
// Valid/ready channel interfaces for the packet receiver.
// hfpr_byte_if carries received bytes, hfpr_frame_if carries decoded frames.
// Depends on hfpr_pkg for field widths.
`default_nettype none

interface hfpr_byte_if;
  logic                         valid;
  logic                         ready;
  logic [hfpr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hfpr_frame_if;
  logic                           valid;
  logic                           ready;
  logic [hfpr_pkg::BYTE_W-1:0]    frame_command;
  logic [hfpr_pkg::PAYLOAD_W-1:0] frame_payload;
  logic                           frame_good;
  logic [hfpr_pkg::BYTE_W-1:0]    computed_sum;

  modport source (output valid, output frame_command, output frame_payload,
                  output frame_good, output computed_sum, input ready);
  modport sink (input valid, input frame_command, input frame_payload,
                input frame_good, input computed_sum, output ready);
endinterface

`default_nettype wire

// ----- rtl/hfpr_parser.sv -----
// Byte input register and frame parser of the packet receiver.
// Tracks the frame position, running checksum, command and payload bytes.
// Depends on hfpr_pkg and hfpr_if.
`default_nettype none

module hfpr_parser #(
  parameter int unsigned PAYLOAD_BYTES = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  hfpr_byte_if.sink                rx,
  input  wire hfpr_pkg::sync_cfg_t sync_cfg,
  input  wire logic                slot_free,
  output logic                     res_valid,
  output hfpr_pkg::frame_t         res
);

  localparam int unsigned POS_CHECK_I = 3 + PAYLOAD_BYTES;
  localparam int unsigned PosW = $clog2(POS_CHECK_I + 1);
  localparam logic [PosW-1:0] POS_HUNT = PosW'(0);
  localparam logic [PosW-1:0] POS_SECOND = PosW'(1);
  localparam logic [PosW-1:0] POS_COMMAND = PosW'(2);
  localparam logic [PosW-1:0] POS_PAYLOAD0 = PosW'(3);
  localparam logic [PosW-1:0] POS_CHECK = PosW'(POS_CHECK_I);

  localparam int unsigned BW = hfpr_pkg::BYTE_W;

  // Input register.
  logic          in_valid;
  logic [BW-1:0] in_byte;

  // Frame state.
  logic [PosW-1:0]                pos;
  logic [PosW-1:0]                pos_next;
  logic [BW-1:0]                  sum;
  logic [BW-1:0]                  sum_next;
  logic [BW-1:0]                  command;
  logic [BW-1:0]                  command_next;
  logic [hfpr_pkg::PAYLOAD_W-1:0] payload;
  logic [hfpr_pkg::PAYLOAD_W-1:0] payload_next;

  logic emit;
  logic advance;

  // The held byte moves on unless it closes a frame while the output is full.
  assign emit = (pos == POS_CHECK);
  assign advance = in_valid && (!emit || slot_free);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Next frame state for the held byte.
  always_comb begin
    pos_next = pos;
    sum_next = sum;
    command_next = command;
    payload_next = payload;
    if (pos == POS_HUNT) begin
      if (in_byte == sync_cfg.first) begin
        sum_next = in_byte;
        pos_next = POS_SECOND;
      end
    end else if (pos == POS_SECOND) begin
      // A wrong second byte drops back to the hunt without being rescanned.
      if (in_byte == sync_cfg.second) begin
        sum_next = sum + in_byte;
        pos_next = POS_COMMAND;
      end else begin
        pos_next = POS_HUNT;
      end
    end else if (pos == POS_COMMAND) begin
      command_next = in_byte;
      payload_next = '0;
      sum_next = sum + in_byte;
      pos_next = POS_PAYLOAD0;
    end else if (pos >= POS_PAYLOAD0 && pos < POS_CHECK) begin
      // Bytes beyond the sixth only enter the checksum.
      for (int k = 0; k < hfpr_pkg::PAYLOAD_SLOTS; k++) begin
        if (k < PAYLOAD_BYTES && pos == PosW'(3 + k)) begin
          payload_next[k*BW +: BW] = in_byte;
        end
      end
      sum_next = sum + in_byte;
      pos_next = pos + PosW'(1);
    end else begin
      // Checksum byte and any meaningless position return to the hunt.
      pos_next = POS_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum <= sum_next;
      command <= command_next;
      payload <= payload_next;
    end
  end

  // Result of the checksum byte.
  assign res_valid = advance && emit;
  assign res.command = command;
  assign res.payload = payload;
  assign res.good = (in_byte == sum);
  assign res.sum = sum;

endmodule

`default_nettype wire

// ----- rtl/hfpr_out_reg.sv -----
// Output register of the packet receiver: holds one decoded frame until taken.
// Frees its slot in the same cycle the sink takes the held frame.
// Depends on hfpr_pkg and hfpr_if.
`default_nettype none

module hfpr_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  input  wire hfpr_pkg::frame_t res,
  output logic                  slot_free,
  hfpr_frame_if.source          frame
);

  logic             valid;
  hfpr_pkg::frame_t data;

  assign slot_free = !valid || frame.ready;

  // Valid flag of the held frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (slot_free) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      data <= res;
    end
  end

  assign frame.valid = valid;
  assign frame.frame_command = data.command;
  assign frame.frame_payload = data.payload;
  assign frame.frame_good = data.good;
  assign frame.computed_sum = data.sum;

endmodule

`default_nettype wire

// ----- rtl/header_framed_packet_receiver_unit.sv -----
// Top level of the header-framed packet receiver.
// Holds the sync header registers and connects the parser to the output register.
// Depends on hfpr_pkg, hfpr_if, hfpr_parser and hfpr_out_reg.
`default_nettype none

// Receives one byte per transaction on rx and hunts for the two-byte sync
// header held in registers 0 (first byte, reset 0xAA) and 1 (second byte,
// reset 0x55). After the header come a command byte, PAYLOAD_BYTES payload
// bytes and a checksum byte; at the checksum byte one transaction on frame
// carries the command, the payload (first payload byte in bits 7:0), the
// 8-bit sum of header, command and payload, and a flag that says whether
// the checksum byte matched it. The block takes one byte every cycle while
// rx.ready is high: a byte goes into an input register and is parsed from
// there into the output register, so a frame is valid once its checksum
// byte has passed through both registers. rx.ready drops only while a
// checksum byte waits for the output register, which is still held by an
// earlier frame the sink has not taken.

module header_framed_packet_receiver_unit #(
  parameter int unsigned PAYLOAD_BYTES = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  hfpr_byte_if.sink                             rx,
  hfpr_frame_if.source                          frame,
  input  wire logic                             cfg_write,
  input  wire logic [hfpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hfpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hfpr_pkg::sync_cfg_t sync_cfg;
  hfpr_pkg::frame_t    res;
  logic                res_valid;
  logic                slot_free;

  // Header byte registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_cfg.first <= hfpr_pkg::SYNC_FIRST_RST;
      sync_cfg.second <= hfpr_pkg::SYNC_SECOND_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        hfpr_pkg::CFG_SYNC_FIRST: begin
          sync_cfg.first <= cfg_data[hfpr_pkg::BYTE_W-1:0];
        end
        hfpr_pkg::CFG_SYNC_SECOND: begin
          sync_cfg.second <= cfg_data[hfpr_pkg::BYTE_W-1:0];
        end
        default: begin
          sync_cfg <= sync_cfg;
        end
      endcase
    end
  end

  hfpr_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .sync_cfg  (sync_cfg),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  hfpr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .frame     (frame)
  );

`ifndef SYNTHESIS
  // A new frame is never written over one the sink has not taken.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> slot_free)
    else $error("frame result issued while the output register is full");

  // A taken frame leaves the output empty unless another one arrives.
  assert property (@(posedge clk) disable iff (rst)
      frame.valid && frame.ready && !res_valid |=> !frame.valid)
    else $error("output stayed valid after its frame was taken");

  // Coming out of reset the receiver can take a byte at once.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> rx.ready)
    else $error("receiver not ready after reset");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the header-framed packet receiver.
// Drives received bytes and header register settings and checks every decoded frame.
// Depends on hfpr_pkg, hfpr_if and the header_framed_packet_receiver_unit RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_BYTES = 135;
  localparam int unsigned NUM_PHASES = 8;

  // Parser positions within a frame.
  localparam logic [3:0] POS_HUNT = 4'd0;
  localparam logic [3:0] POS_SECOND = 4'd1;
  localparam logic [3:0] POS_COMMAND = 4'd2;
  localparam logic [3:0] POS_PAYLOAD0 = 4'd3;
  localparam logic [3:0] POS_CHECK = POS_PAYLOAD0 + 4'(PAYLOAD_BYTES);

  // One row of the directed table: a byte and, where it ends a frame whose
  // outcome is obvious, the frame that must come out.
  typedef struct packed {
    logic [hfpr_pkg::BYTE_W-1:0] rx;
    logic                        typed;
    hfpr_pkg::frame_t            want;
  } stim_row_t;

  localparam hfpr_pkg::frame_t NO_FRAME = '0;
  localparam int unsigned DIRECTED_LEN = 24;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // Noise, then a first header byte followed by itself: the repeat must
    // send the parser back to the hunt, so the 0x55 after it starts nothing.
    '{8'h00, 1'b0, NO_FRAME},
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'h55, 1'b0, NO_FRAME},
    // All-zero frame with a matching checksum.
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'h55, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'hFF, 1'b1, '{8'h00, 48'h0, 1'b1, 8'hFF}},
    // All-ones frame with a wrong checksum; the sum wraps to 0xF8.
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'h55, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'h00, 1'b1, '{8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 8'hF8}}
  };

  // Header register settings per random phase; random entries are drawn at run time.
  localparam logic [7:0] PHASE_FIRST [NUM_PHASES] =
    '{8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hAA};
  localparam logic [7:0] PHASE_SECOND [NUM_PHASES] =
    '{8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h55};
  localparam bit PHASE_RANDOM [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};

  logic clk;
  logic rst;
  logic cfg_write;
  logic [hfpr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hfpr_pkg::CFG_DATA_W-1:0] cfg_data;
  logic sink_ready = 1'b0;

  hfpr_byte_if rx_ch();
  hfpr_frame_if frame_ch();

  assign frame_ch.ready = sink_ready;

  header_framed_packet_receiver_unit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .frame(frame_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: the header registers and the frame being assembled.
  logic [7:0] sync_first_q = hfpr_pkg::SYNC_FIRST_RST;
  logic [7:0] sync_second_q = hfpr_pkg::SYNC_SECOND_RST;
  logic [3:0] rx_pos = POS_HUNT;
  logic [7:0] rx_sum = '0;
  logic [7:0] held_cmd = '0;
  logic [hfpr_pkg::PAYLOAD_W-1:0] held_pay = '0;

  hfpr_pkg::frame_t frames_due[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned frames_good = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_cycle = 0;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advances the frame parser by one byte; returns 1 when a frame completes.
  function automatic bit decode_rx_byte(input logic [7:0] b, output hfpr_pkg::frame_t f);
    int unsigned slot;
    bit done;
    done = 1'b0;
    f = '0;
    if (rx_pos == POS_HUNT) begin
      if (b == sync_first_q) begin
        rx_sum = b;
        rx_pos = POS_SECOND;
      end
    end else if (rx_pos == POS_SECOND) begin
      // A wrong second byte is dropped, never reused as a first header byte.
      if (b == sync_second_q) begin
        rx_sum = rx_sum + b;
        rx_pos = POS_COMMAND;
      end else begin
        rx_pos = POS_HUNT;
      end
    end else if (rx_pos == POS_COMMAND) begin
      held_cmd = b;
      held_pay = '0;
      rx_sum = rx_sum + b;
      rx_pos = POS_PAYLOAD0;
    end else if (rx_pos >= POS_PAYLOAD0 && rx_pos < POS_CHECK) begin
      slot = rx_pos - POS_PAYLOAD0;
      if (slot < hfpr_pkg::PAYLOAD_SLOTS) begin
        held_pay[8*slot +: 8] = b;
      end
      rx_sum = rx_sum + b;
      rx_pos = rx_pos + 4'd1;
    end else if (rx_pos == POS_CHECK) begin
      f.command = held_cmd;
      f.payload = held_pay;
      f.good = (b == rx_sum);
      f.sum = rx_sum;
      rx_pos = POS_HUNT;
      done = 1'b1;
    end else begin
      rx_pos = POS_HUNT;
    end
    return done;
  endfunction

  // Sends one byte in bursts with random gaps and records the frame it completes.
  task automatic send_rx_byte(input logic [7:0] b, input bit typed,
                              input hfpr_pkg::frame_t want);
    hfpr_pkg::frame_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    if (decode_rx_byte(b, predicted) || typed) begin
      frames_due.push_back(typed ? want : predicted);
    end
  endtask

  // Holds the byte stream back until every expected frame has come out.
  task automatic drain_frames();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed table, then random phases under different header settings.
  initial begin
    logic [7:0] stream[$];
    logic [7:0] first_v;
    logic [7:0] second_v;
    logic [7:0] v;
    logic [7:0] sum;
    int unsigned r;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= hfpr_pkg::CFG_SYNC_FIRST;
    cfg_data <= '0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_rx_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_frames();
      first_v = PHASE_RANDOM[p] ? 8'($urandom) : PHASE_FIRST[p];
      second_v = PHASE_RANDOM[p] ? 8'($urandom) : PHASE_SECOND[p];

      // Both header registers are written on back-to-back cycles while idle.
      cfg_write <= 1'b1;
      cfg_index <= hfpr_pkg::CFG_SYNC_FIRST;
      cfg_data <= first_v;
      @(posedge clk);
      cfg_index <= hfpr_pkg::CFG_SYNC_SECOND;
      cfg_data <= second_v;
      @(posedge clk);
      cfg_write <= 1'b0;
      sync_first_q = first_v;
      sync_second_q = second_v;

      // Mostly well-formed frames with random content, plus noise,
      // broken headers and frames cut short.
      stream.delete();
      while (stream.size() < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          stream.push_back(first_v);
          stream.push_back(second_v);
          sum = first_v + second_v;
          repeat (1 + PAYLOAD_BYTES) begin
            v = 8'($urandom);
            stream.push_back(v);
            sum = sum + v;
          end
          if ($urandom_range(0, 3) != 0) begin
            stream.push_back(sum);
          end else begin
            stream.push_back(sum + 8'($urandom_range(1, 255)));
          end
        end else if (r < 80) begin
          repeat ($urandom_range(1, 5)) stream.push_back(8'($urandom));
        end else if (r < 90) begin
          stream.push_back(first_v);
          if (first_v != second_v && $urandom_range(0, 1) == 1) begin
            stream.push_back(first_v);
          end else begin
            stream.push_back(second_v + 8'($urandom_range(1, 255)));
          end
        end else begin
          stream.push_back(first_v);
          stream.push_back(second_v);
          repeat ($urandom_range(1, PAYLOAD_BYTES)) stream.push_back(8'($urandom));
        end
      end
      foreach (stream[i]) begin
        send_rx_byte(stream[i], 1'b0, NO_FRAME);
      end
    end

    drain_frames();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes under %0d header settings; checked %0d frames (%0d good, %0d bad).",
             bytes_sent, NUM_PHASES + 1, frames_checked, frames_good,
             frames_checked - frames_good);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Frame checker and receiver stall pattern; stall density changes over time.
  always @(posedge clk) begin
    hfpr_pkg::frame_t exp_frame;
    int unsigned stall_pct;
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
      sink_cycle <= 0;
    end else begin
      if (frame_ch.valid && sink_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: command %h payload %h good %b sum %h",
                 frame_ch.frame_command, frame_ch.frame_payload,
                 frame_ch.frame_good, frame_ch.computed_sum);
          errors++;
        end else begin
          exp_frame = frames_due.pop_front();
          frames_checked++;
          if (exp_frame.good) frames_good++;
          if (frame_ch.frame_command !== exp_frame.command) begin
            $error("frame_command: expected %h, got %h", exp_frame.command,
                   frame_ch.frame_command);
            errors++;
          end
          if (frame_ch.frame_payload !== exp_frame.payload) begin
            $error("frame_payload: expected %h, got %h", exp_frame.payload,
                   frame_ch.frame_payload);
            errors++;
          end
          if (frame_ch.frame_good !== exp_frame.good) begin
            $error("frame_good: expected %b, got %b", exp_frame.good, frame_ch.frame_good);
            errors++;
          end
          if (frame_ch.computed_sum !== exp_frame.sum) begin
            $error("computed_sum: expected %h, got %h", exp_frame.sum, frame_ch.computed_sum);
            errors++;
          end
        end
      end

      case ((sink_cycle / 256) % 3)
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 60;
      endcase
      sink_cycle <= sink_cycle + 1;
      if (stall_left != 0) begin
        sink_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        sink_ready <= 1'b0;
        stall_left <= $urandom_range(0, 23);
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (frame_ch.valid && sink_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
